### rtl/gslm_pkg.sv
// ----------------------------------------------------------------------------
// gslm_pkg: shared definitions for the strict 3x3 local-maximum finder
// Sizes, register indexes, the word carried from front to back, and the
// neighbor offset tables.
// ----------------------------------------------------------------------------
package gslm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 16;

    localparam int SIZE_BITS = 11;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT) + 3;
    localparam int TOTAL_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int POS_BITS = ROW_BITS + SIZE_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int DIV_STEPS = TOTAL_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam int WINDOW_SIZE = 9;
    localparam int NB_COUNT = 8;
    localparam int NB_DROW [NB_COUNT] = '{0, 0, 1, -1, -1, -1, 1, 1};
    localparam int NB_DCOL [NB_COUNT] = '{1, -1, 0, 0, -1, 1, 1, -1};

    typedef enum logic [1:0] {
        ST_RUN,
        ST_TOTAL,
        ST_POS,
        ST_DIV
    } front_state_t;

    typedef struct packed {
        logic [COL_BITS-1:0]   col_idx;
        logic [PIXEL_BITS-1:0] value;
        logic                  emit;
        logic                  restart;
        logic                  last;
        logic [SIZE_BITS-1:0]  row_num;
        logic [SIZE_BITS-1:0]  col_num;
        logic                  up_ok;
        logic                  down_ok;
        logic                  left_ok;
        logic                  right_ok;
    } gslm_item_t;

endpackage

### rtl/gslm_front.sv
// ----------------------------------------------------------------------------
// gslm_front: input classification and raster bookkeeping
// Holds the frame size, the input and decision counters, and recomputes the
// derived counters after a register write with a serial divider.
// ----------------------------------------------------------------------------
module gslm_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gslm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gslm_pkg::SIZE_BITS-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [gslm_pkg::PIXEL_BITS-1:0]      s_pixel_value,
    input  logic                                 queue_full,
    output logic                                 push,
    output gslm_pkg::gslm_item_t                 push_item
);
    import gslm_pkg::*;

    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] value,
                                                        input logic [SIZE_BITS-1:0] limit);
        logic [SIZE_BITS-1:0] result;
        if (value == '0) begin
            result = SIZE_BITS'(1);
        end else if (value > limit) begin
            result = limit;
        end else begin
            result = value;
        end
        return result;
    endfunction

    front_state_t state_reg, state_next;

    logic [SIZE_BITS-1:0]    frame_w_reg;
    logic [SIZE_BITS-1:0]    frame_h_reg;
    logic [TOTAL_BITS-1:0]   total_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic [SIZE_BITS-1:0]    in_col_reg;
    logic [ROW_BITS-1:0]     in_row_reg;
    logic [TOTAL_BITS-1:0]   out_index_reg;
    logic [SIZE_BITS-1:0]    out_row_reg;
    logic [SIZE_BITS-1:0]    out_col_reg;
    logic [TOTAL_BITS-1:0]   div_quo_reg;
    logic [SIZE_BITS-1:0]    div_rem_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;

    logic                    cfg_write;
    logic                    accept;
    logic                    col_wrap;
    logic [SIZE_BITS-1:0]    col_now;
    logic [ROW_BITS-1:0]     row_now;
    logic [SIZE_BITS-1:0]    col_inc;
    logic                    col_end;
    logic                    pixel_phase;
    logic                    ignore;
    logic                    early;
    logic                    out_done;
    logic [TOTAL_BITS-1:0]   out_inc;
    logic                    last;
    logic                    emit;
    logic                    restart;
    logic [SIZE_BITS-1:0]    ocol_inc;
    logic [SIZE_BITS-1:0]    orow_inc;
    logic [SIZE_BITS:0]      div_shift;
    logic                    div_fit;
    logic [SIZE_BITS-1:0]    div_rem_next;
    logic [TOTAL_BITS-1:0]   div_quo_next;

    assign cfg_write = cfg_valid && cfg_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                state_next = ST_RUN;
            end
            ST_TOTAL: begin
                state_next = ST_POS;
            end
            ST_POS: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
        if (cfg_write) begin
            state_next = ST_TOTAL;
        end
    end

    always_comb begin
        cfg_ready = 1'b1;
        unique case (state_reg)
            ST_RUN: begin
                s_ready = !queue_full;
            end
            ST_TOTAL, ST_POS, ST_DIV: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        col_wrap = in_col_reg >= frame_w_reg;
        col_now = col_wrap ? '0 : in_col_reg;
        row_now = in_row_reg + ROW_BITS'(col_wrap);
        col_inc = col_now + SIZE_BITS'(1);
        col_end = col_inc == frame_w_reg;
        pixel_phase = pos_reg < POS_BITS'(total_reg);
        ignore = pixel_phase && s_opcode;
        early = pos_reg < (POS_BITS'(frame_w_reg) + POS_BITS'(1));
        out_done = out_index_reg >= total_reg;
        out_inc = out_index_reg + TOTAL_BITS'(1);
        last = out_inc == total_reg;
        emit = !early && !out_done;
        restart = !early && out_done;
        ocol_inc = out_col_reg + SIZE_BITS'(1);
        orow_inc = out_row_reg + SIZE_BITS'(1);

        push = accept && !ignore;
        push_item.col_idx = col_now[COL_BITS-1:0];
        push_item.value = pixel_phase ? s_pixel_value : '0;
        push_item.emit = emit;
        push_item.restart = restart;
        push_item.last = last;
        push_item.row_num = orow_inc;
        push_item.col_num = ocol_inc;
        push_item.up_ok = out_row_reg != '0;
        push_item.down_ok = orow_inc < frame_h_reg;
        push_item.left_ok = out_col_reg != '0;
        push_item.right_ok = ocol_inc < frame_w_reg;
    end

    always_comb begin
        div_shift = {div_rem_reg, div_quo_reg[TOTAL_BITS-1]};
        div_fit = div_shift >= {1'b0, frame_w_reg};
        if (div_fit) begin
            div_rem_next = SIZE_BITS'(div_shift - {1'b0, frame_w_reg});
        end else begin
            div_rem_next = div_shift[SIZE_BITS-1:0];
        end
        div_quo_next = {div_quo_reg[TOTAL_BITS-2:0], div_fit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            frame_w_reg <= SIZE_BITS'(MAX_WIDTH);
            frame_h_reg <= SIZE_BITS'(MAX_HEIGHT);
            total_reg <= TOTAL_BITS'(MAX_WIDTH * MAX_HEIGHT);
            pos_reg <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_index_reg <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        frame_w_reg <= clamp_size(cfg_data, SIZE_BITS'(MAX_WIDTH));
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_h_reg <= clamp_size(cfg_data, SIZE_BITS'(MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
            unique case (state_reg)
                ST_TOTAL: begin
                    total_reg <= TOTAL_BITS'(frame_w_reg) * TOTAL_BITS'(frame_h_reg);
                end
                ST_POS: begin
                    pos_reg <= POS_BITS'(row_now) * POS_BITS'(frame_w_reg) + POS_BITS'(col_now);
                    div_cnt_reg <= '0;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_BITS'(1);
                    if (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                        out_row_reg <= div_quo_next[SIZE_BITS-1:0];
                        out_col_reg <= div_rem_next;
                    end
                end
                ST_RUN: begin
                    if (accept) begin
                        if (ignore) begin
                            in_col_reg <= col_now;
                            in_row_reg <= row_now;
                        end else if (restart || (emit && last)) begin
                            pos_reg <= '0;
                            in_col_reg <= '0;
                            in_row_reg <= '0;
                            out_index_reg <= '0;
                            out_row_reg <= '0;
                            out_col_reg <= '0;
                        end else begin
                            in_col_reg <= col_end ? '0 : col_inc;
                            in_row_reg <= col_end ? row_now + ROW_BITS'(1) : row_now;
                            pos_reg <= pos_reg + POS_BITS'(1);
                            if (emit) begin
                                out_index_reg <= out_inc;
                                if (ocol_inc == frame_w_reg) begin
                                    out_col_reg <= '0;
                                    out_row_reg <= orow_inc;
                                end else begin
                                    out_col_reg <= ocol_inc;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_POS) begin
            div_quo_reg <= out_index_reg;
            div_rem_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            div_quo_reg <= div_quo_next;
            div_rem_reg <= div_rem_next;
        end
    end

    a_in_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_write) |=> (in_col_reg < frame_w_reg))
        else $error("Input column left the frame after an accepted word.");

    a_out_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (out_col_reg < frame_w_reg))
        else $error("Decision column is outside the frame while running.");

endmodule

### rtl/gslm_fifo.sv
// ----------------------------------------------------------------------------
// gslm_fifo: short queue between the front and the back
// Holds classified words so that each side can stall on its own.
// ----------------------------------------------------------------------------
module gslm_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  gslm_pkg::gslm_item_t push_item,
    input  logic                 pop,
    output gslm_pkg::gslm_item_t head_item,
    output logic                 empty,
    output logic                 full
);
    import gslm_pkg::*;

    localparam logic [QPTR_BITS:0] FULL_COUNT = (QPTR_BITS + 1)'(QUEUE_DEPTH);

    gslm_item_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign head_item = slot_reg[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign full = count_reg == FULL_COUNT;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_BITS + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_BITS + 1)'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("Word pushed into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("Word popped from an empty queue.");

endmodule

### rtl/gslm_back.sv
// ----------------------------------------------------------------------------
// gslm_back: line buffers, 3x3 window and peak decision
// Reads and updates the two line buffers, shifts the window, compares the
// center against its in-frame neighbors and registers the result word.
// ----------------------------------------------------------------------------
module gslm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gslm_pkg::gslm_item_t            head_item,
    input  logic                            queue_empty,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gslm_pkg::SIZE_BITS-1:0]  m_peak_row,
    output logic [gslm_pkg::SIZE_BITS-1:0]  m_peak_col,
    output logic                            m_is_peak,
    output logic                            m_frame_last,
    output logic                            m_no_peak_in_frame
);
    import gslm_pkg::*;

    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

    logic                  advance;
    logic                  s1_valid_reg;
    gslm_item_t            s1_item_reg;
    logic [PIXEL_BITS-1:0] upper_rd_reg;
    logic [PIXEL_BITS-1:0] lower_rd_reg;
    logic                  fwd_reg;
    logic [PIXEL_BITS-1:0] fwd_data_reg;
    logic [PIXEL_BITS-1:0] upper_val;

    logic                  s2_valid_reg;
    gslm_item_t            s2_item_reg;
    logic [PIXEL_BITS-1:0] window_reg [WINDOW_SIZE];
    logic                  peak_seen_reg;

    logic [NB_COUNT-1:0]   nb_ok;
    logic                  peak;

    logic                  m_valid_reg;
    logic [SIZE_BITS-1:0]  peak_row_reg;
    logic [SIZE_BITS-1:0]  peak_col_reg;
    logic                  is_peak_reg;
    logic                  frame_last_reg;
    logic                  no_peak_reg;

    assign advance = !m_valid_reg || m_ready;
    assign pop = advance && !queue_empty;
    assign upper_val = fwd_reg ? fwd_data_reg : upper_rd_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            upper_rd_reg <= upper_mem[head_item.col_idx];
        end
        if (advance && s1_valid_reg) begin
            upper_mem[s1_item_reg.col_idx] <= lower_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            lower_rd_reg <= lower_mem[head_item.col_idx];
            lower_mem[head_item.col_idx] <= head_item.value;
        end
    end

    always_comb begin
        for (int n = 0; n < NB_COUNT; n++) begin
            nb_ok[n] = ((NB_DROW[n] == 0) ||
                        ((NB_DROW[n] < 0) ? s2_item_reg.up_ok : s2_item_reg.down_ok)) &&
                       ((NB_DCOL[n] == 0) ||
                        ((NB_DCOL[n] < 0) ? s2_item_reg.left_ok : s2_item_reg.right_ok));
        end
    end

    always_comb begin
        peak = 1'b1;
        for (int n = 0; n < NB_COUNT; n++) begin
            if (nb_ok[n] &&
                !(window_reg[(1 + NB_DROW[n]) * 3 + 1 + NB_DCOL[n]] < window_reg[4])) begin
                peak = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_item_reg <= head_item;
            fwd_data_reg <= lower_rd_reg;
        end
        if (advance && s1_valid_reg) begin
            s2_item_reg <= s1_item_reg;
        end
        if (advance && s2_valid_reg && s2_item_reg.emit) begin
            peak_row_reg <= s2_item_reg.row_num;
            peak_col_reg <= s2_item_reg.col_num;
            is_peak_reg <= peak;
            frame_last_reg <= s2_item_reg.last;
            no_peak_reg <= s2_item_reg.last && !(peak_seen_reg || peak);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            peak_seen_reg <= 1'b0;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                window_reg[i] <= '0;
            end
        end else if (advance) begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg <= s2_valid_reg && s2_item_reg.emit;
            if (pop) begin
                fwd_reg <= s1_valid_reg && (s1_item_reg.col_idx == head_item.col_idx);
            end
            if (s1_valid_reg) begin
                for (int r = 0; r < 3; r++) begin
                    window_reg[r * 3] <= window_reg[r * 3 + 1];
                    window_reg[r * 3 + 1] <= window_reg[r * 3 + 2];
                end
                window_reg[2] <= upper_val;
                window_reg[5] <= lower_rd_reg;
                window_reg[8] <= s1_item_reg.value;
            end
            if (s2_valid_reg) begin
                if (s2_item_reg.restart || (s2_item_reg.emit && s2_item_reg.last)) begin
                    peak_seen_reg <= 1'b0;
                end else if (s2_item_reg.emit && peak) begin
                    peak_seen_reg <= 1'b1;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_peak_row = peak_row_reg;
    assign m_peak_col = peak_col_reg;
    assign m_is_peak = is_peak_reg;
    assign m_frame_last = frame_last_reg;
    assign m_no_peak_in_frame = no_peak_reg;

    a_no_peak_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !frame_last_reg) |-> !no_peak_reg)
        else $error("Empty-frame flag set on a word that does not end the frame.");

endmodule

### rtl/grid_strict_local_max_3x3.sv
// ----------------------------------------------------------------------------
// grid_strict_local_max_3x3: strict 3x3 local-maximum finder
// Marks each pixel of a raster-order grid that is strictly above all of its
// in-frame neighbors.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_ channel in raster order, one word per clock while
// s_ready is high. A word with s_opcode set is a pad tick; pads sent while
// frame pixels are still expected are dropped. After the last pixel,
// frame_width + 1 pad ticks flush the remaining decisions. The decision for
// pixel k is caused by input word k + frame_width + 1 and leaves, registered,
// on the m_ channel in raster order, with one-based row and column. The word
// for the final pixel carries m_frame_last and, if no peak was found, also
// m_no_peak_in_frame. Both channels carry one word per cycle while neither
// stalls. Registers are to be written by the user through the cfg_ channel
// only while the block is idle; the block itself does not enforce this. After
// each write s_ready stays low while the frame total and the raster counters
// are recomputed with a one-bit-per-cycle divider. After reset the frame is
// 1024 x 1024 and the line buffers hold no data. When the receiver stalls,
// the result register holds its word, the back pipeline stops, and the front
// keeps taking words until its four-entry queue is full.
// ----------------------------------------------------------------------------
module grid_strict_local_max_3x3 (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gslm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gslm_pkg::SIZE_BITS-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [gslm_pkg::PIXEL_BITS-1:0]     s_pixel_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gslm_pkg::SIZE_BITS-1:0]      m_peak_row,
    output logic [gslm_pkg::SIZE_BITS-1:0]      m_peak_col,
    output logic                                m_is_peak,
    output logic                                m_frame_last,
    output logic                                m_no_peak_in_frame
);
    import gslm_pkg::*;

    logic       queue_full;
    logic       queue_empty;
    logic       push;
    logic       pop;
    gslm_item_t push_item;
    gslm_item_t head_item;

    gslm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_pixel_value (s_pixel_value),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    gslm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    gslm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_item          (head_item),
        .queue_empty        (queue_empty),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_peak_row         (m_peak_row),
        .m_peak_col         (m_peak_col),
        .m_is_peak          (m_is_peak),
        .m_frame_last       (m_frame_last),
        .m_no_peak_in_frame (m_no_peak_in_frame)
    );

endmodule
